### hw/rtl/lud_pkg.sv
package lud_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CpW   = 21;
  localparam int unsigned LenW  = 3;
  localparam int unsigned CntW  = 3;
  localparam int unsigned MaxRun = 4;

  localparam logic [1:0] ContTag  = 2'h2;   // 10xxxxxx
  localparam logic [2:0] Lead2Tag = 3'h6;   // 110xxxxx
  localparam logic [3:0] Lead3Tag = 4'hE;   // 1110xxxx
  localparam logic [4:0] Lead4Tag = 5'h1E;  // 11110xxx

  localparam logic [LenW-1:0] LenRaw = 3'd1;

  typedef struct packed {
    logic [CpW-1:0]  cp;
    logic [LenW-1:0] len;
  } entry_t;

  typedef struct packed {
    logic [CntW-1:0]       cnt;
    entry_t [MaxRun-1:0]   ent;
    logic                  last_text;
  } run_t;

  // continuation bytes a lead byte asks for, 0 when it is not a lead
  function automatic logic [1:0] lead_need(input logic [ByteW-1:0] b);
    logic [1:0] n;
    n = 2'd0;
    if (b[7:5] == Lead2Tag)      n = 2'd1;
    else if (b[7:4] == Lead3Tag) n = 2'd2;
    else if (b[7:3] == Lead4Tag) n = 2'd3;
    return n;
  endfunction

  function automatic logic is_cont(input logic [ByteW-1:0] b);
    return b[7:6] == ContTag;
  endfunction

  function automatic entry_t raw_ent(input logic [ByteW-1:0] b);
    entry_t e;
    e.cp  = {{(CpW-ByteW){1'b0}}, b};
    e.len = LenRaw;
    return e;
  endfunction

endpackage

### hw/rtl/lud_if.sv
interface lud_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       text_end;

  modport source (output valid, output in_byte, output text_end, input ready);
  modport sink (input valid, input in_byte, input text_end, output ready);
endinterface

interface lud_out_if;
  logic        valid;
  logic        ready;
  logic [20:0] code_point;
  logic [2:0]  seq_len;
  logic        last_of_text;
  logic        last_of_run;

  modport source (output valid, output code_point, output seq_len,
                  output last_of_text, output last_of_run, input ready);
  modport sink (input valid, input code_point, input seq_len,
                input last_of_text, input last_of_run, output ready);
endinterface

### hw/rtl/lud_dec.sv
module lud_dec (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       take_i,
  input  logic [lud_pkg::ByteW-1:0]  byte_i,
  input  logic                       end_i,
  output lud_pkg::run_t              run_o
);

  logic [lud_pkg::ByteW-1:0] lead_q, lead_d;
  logic [lud_pkg::ByteW-1:0] cont_q [2];
  logic [lud_pkg::ByteW-1:0] cont_d [2];
  logic [1:0]                need_q, need_d;
  logic [1:0]                have_q, have_d;

  logic [1:0]               f_need;
  logic                     f_raw;
  lud_pkg::entry_t          fl [4];
  logic [lud_pkg::CntW-1:0] fl_n;
  lud_pkg::entry_t          dec_ent;

  always_comb begin
    f_need = lud_pkg::lead_need(byte_i);
    f_raw  = (f_need == 2'd0) || end_i;
    fl[0]  = lud_pkg::raw_ent(lead_q);
    fl[1]  = lud_pkg::raw_ent(cont_q[0]);
    fl[2]  = lud_pkg::raw_ent(cont_q[1]);
    fl[3]  = lud_pkg::raw_ent(byte_i);
    fl_n   = lud_pkg::CntW'(have_q) + 3'd1;

    case (need_q)
      2'd1: dec_ent.cp = {10'd0, lead_q[4:0], byte_i[5:0]};
      2'd2: dec_ent.cp = {5'd0, lead_q[3:0], cont_q[0][5:0], byte_i[5:0]};
      default: dec_ent.cp = {lead_q[2:0], cont_q[0][5:0], cont_q[1][5:0], byte_i[5:0]};
    endcase
    dec_ent.len = lud_pkg::LenW'(need_q) + 3'd1;
  end

  always_comb begin
    run_o.cnt       = '0;
    run_o.ent       = '0;
    run_o.last_text = end_i;
    lead_d = lead_q;
    cont_d = cont_q;
    need_d = need_q;
    have_d = have_q;

    if (need_q == 2'd0) begin
      if (f_raw) begin
        run_o.cnt    = 3'd1;
        run_o.ent[0] = lud_pkg::raw_ent(byte_i);
      end else begin
        lead_d = byte_i;
        need_d = f_need;
        have_d = 2'd0;
      end
    end else if (lud_pkg::is_cont(byte_i)) begin
      if (have_q + 2'd1 == need_q) begin
        run_o.cnt    = 3'd1;
        run_o.ent[0] = dec_ent;
        need_d = 2'd0;
        have_d = 2'd0;
        lead_d = '0;
      end else if (end_i) begin
        // early end: flush held bytes, then this byte raw
        for (int i = 0; i < lud_pkg::MaxRun; i++) begin
          run_o.ent[i] = (3'(i) < fl_n) ? fl[i] : fl[3];
        end
        run_o.cnt = fl_n + 3'd1;
        need_d = 2'd0;
        have_d = 2'd0;
        lead_d = '0;
      end else begin
        cont_d[have_q[0]] = byte_i;
        have_d = have_q + 2'd1;
      end
    end else begin
      // broken sequence: flush, then treat the byte as fresh
      for (int i = 0; i < lud_pkg::MaxRun; i++) begin
        run_o.ent[i] = (3'(i) < fl_n) ? fl[i] : fl[3];
      end
      run_o.cnt = f_raw ? fl_n + 3'd1 : fl_n;
      need_d = 2'd0;
      have_d = 2'd0;
      lead_d = '0;
      if (!f_raw) begin
        lead_d = byte_i;
        need_d = f_need;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_q <= '0;
      need_q <= '0;
      have_q <= '0;
    end else if (take_i) begin
      lead_q <= lead_d;
      need_q <= need_d;
      have_q <= have_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      cont_q <= cont_d;
    end
  end

endmodule

### hw/rtl/lud_emit.sv
module lud_emit (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  lud_pkg::run_t   run_i,
  output logic            free_o,
  lud_out_if.source       out_o
);

  lud_pkg::run_t run_q;
  logic [1:0]    idx_q;
  logic          valid_q;
  logic          last;
  logic          fire;

  assign last = (lud_pkg::CntW'(idx_q) + 3'd1) == run_q.cnt;
  assign fire = valid_q && out_o.ready;
  assign free_o = !valid_q || (fire && last);

  assign out_o.valid        = valid_q;
  assign out_o.code_point   = run_q.ent[idx_q].cp;
  assign out_o.seq_len      = run_q.ent[idx_q].len;
  assign out_o.last_of_run  = last;
  assign out_o.last_of_text = last && run_q.last_text;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (load_i) begin
      valid_q <= 1'b1;
      idx_q   <= '0;
    end else if (fire) begin
      if (last) begin
        valid_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      run_q <= run_i;
    end
  end

endmodule

### hw/rtl/lenient_utf8_decoder.sv
// an accepted byte waits in the input register until the result buffer can take its run
// throughput: one byte per cycle while each byte gives at most one result and the port is ready
// a byte that flushes a broken sequence gives up to four results, one per cycle while
// the result port is ready, and holds the input back until the last of them is taken
// reset: asynchronous, active low; clears the open sequence and empties both stages
module lenient_utf8_decoder (
  input  logic      clk_i,
  input  logic      rst_ni,
  lud_in_if.sink    in_i,
  lud_out_if.source out_o
);

  // input register: one held request
  logic                      inq_valid_q;
  logic [lud_pkg::ByteW-1:0] inq_byte_q;
  logic                      inq_end_q;

  // decoder state advances only when the held byte's run can be handed on
  logic          take;
  logic          run_free;
  lud_pkg::run_t run;
  logic          load;

  assign take     = inq_valid_q && run_free;
  // bytes that only extend a sequence leave no run behind
  assign load     = take && (run.cnt != '0);
  assign in_i.ready = !inq_valid_q || take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inq_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      inq_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      inq_byte_q <= in_i.in_byte;
      inq_end_q  <= in_i.text_end;
    end
  end

  // sequence tracking and code point assembly
  lud_dec u_dec (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (take),
    .byte_i (inq_byte_q),
    .end_i  (inq_end_q),
    .run_o  (run)
  );

  // result buffer: plays out one run, one value per request
  lud_emit u_emit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (load),
    .run_i  (run),
    .free_o (run_free),
    .out_o  (out_o)
  );

  // a run is never longer than four values
  a_run_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |-> run.cnt <= 3'd4)
    else $error("run longer than four values");

  // a byte carrying the text end always produces at least one value
  a_end_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && inq_end_q |-> run.cnt != '0)
    else $error("text end produced no result");

  // a loaded run shows up on the result port next cycle
  a_load_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> out_o.valid)
    else $error("loaded run not presented");

  // the end of text only marks the last value of a run
  a_text_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.last_of_text |-> out_o.last_of_run)
    else $error("last_of_text without last_of_run");

endmodule
